// ===== rtl/core/bqpp_pkg.sv =====
package bqpp_pkg;

   localparam int FRAC_BITS   = 8;
   localparam int SAMPLE_BITS = 16;
   localparam int COEF_BITS   = 16;
   localparam int ACC_BITS    = 32;
   localparam int CSR_IDX_BITS = 3;

   localparam logic [COEF_BITS-1:0] B0_RESET = 16'd140;
   localparam logic [COEF_BITS-1:0] B1_RESET = 16'hFEE8;
   localparam logic [COEF_BITS-1:0] B2_RESET = 16'd140;
   localparam logic [COEF_BITS-1:0] A1_RESET = 16'd225;
   localparam logic [COEF_BITS-1:0] A2_RESET = 16'hFFB0;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_B0 = 3'd0,
      CSR_B1 = 3'd1,
      CSR_B2 = 3'd2,
      CSR_A1 = 3'd3,
      CSR_A2 = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST_PROD,
      ST_FIRST_FB,
      ST_SECOND_PROD,
      ST_SECOND_FB,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic load_samples;
      logic do_prod;
      logic do_fb;
      logic sel_second;
      logic load_out;
   } cmd_type;

   function automatic logic [ACC_BITS-1:0] scale(input logic [ACC_BITS-1:0] p);
      scale = ACC_BITS'($signed(p) >>> FRAC_BITS);
   endfunction

endpackage

// ===== rtl/core/biquad_iir_packed_pair_top.sv =====
// Biquad IIR filter, transposed form, Q8 coefficients, over packed pairs of
// signed 16-bit samples (first sample filtered first). Each sample takes a
// product step (b0/b1/b2 products and output y), then a feedback step (a1/a2
// products that update the two delay terms). A result register lets the next
// word start from idle while a result waits; a word that ends while a
// result waits is held until that result is taken. Coefficients are written
// through csr_we/csr_index/csr_data; the user must write them only while
// idle, which the block does not enforce. Indexes above four are ignored.
module biquad_iir_packed_pair_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [bqpp_pkg::SAMPLE_BITS-1:0] req_sample_first,
   input  logic signed [bqpp_pkg::SAMPLE_BITS-1:0] req_sample_second,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [bqpp_pkg::SAMPLE_BITS-1:0] rsp_filtered_first,
   output logic signed [bqpp_pkg::SAMPLE_BITS-1:0] rsp_filtered_second,
   input  logic                                    csr_we,
   input  logic [bqpp_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [bqpp_pkg::COEF_BITS-1:0]          csr_data
);

   bqpp_pkg::cmd_type cmd;

   bqpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   bqpp_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_sample_first    (req_sample_first),
      .req_sample_second   (req_sample_second),
      .rsp_filtered_first  (rsp_filtered_first),
      .rsp_filtered_second (rsp_filtered_second)
   );

endmodule

// ===== rtl/core/bqpp_ctrl.sv =====
module bqpp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bqpp_pkg::cmd_type cmd
);

   bqpp_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free, final_step, accept;

   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      final_step = (state_ff == bqpp_pkg::ST_SECOND_FB) || (state_ff == bqpp_pkg::ST_HOLD);
      req_stall  = !((state_ff == bqpp_pkg::ST_IDLE) || (final_step && out_free));
      accept     = req_valid && !req_stall;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bqpp_pkg::ST_IDLE: begin
            if (accept) state_in = bqpp_pkg::ST_FIRST_PROD;
         end
         bqpp_pkg::ST_FIRST_PROD:  state_in = bqpp_pkg::ST_FIRST_FB;
         bqpp_pkg::ST_FIRST_FB:    state_in = bqpp_pkg::ST_SECOND_PROD;
         bqpp_pkg::ST_SECOND_PROD: state_in = bqpp_pkg::ST_SECOND_FB;
         bqpp_pkg::ST_SECOND_FB, bqpp_pkg::ST_HOLD: begin
            if (!out_free) state_in = bqpp_pkg::ST_HOLD;
            else if (accept) state_in = bqpp_pkg::ST_FIRST_PROD;
            else state_in = bqpp_pkg::ST_IDLE;
         end
         default: state_in = bqpp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.load_samples = accept;
      cmd.load_out     = final_step && out_free;
      case (state_ff)
         bqpp_pkg::ST_FIRST_PROD: cmd.do_prod = 1'b1;
         bqpp_pkg::ST_FIRST_FB:   cmd.do_fb   = 1'b1;
         bqpp_pkg::ST_SECOND_PROD: begin
            cmd.do_prod    = 1'b1;
            cmd.sel_second = 1'b1;
         end
         bqpp_pkg::ST_SECOND_FB: begin
            cmd.do_fb      = 1'b1;
            cmd.sel_second = 1'b1;
         end
         default: cmd.sel_second = 1'b1;
      endcase
      rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_stall && rsp_valid_ff);
      rsp_valid    = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bqpp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/bqpp_datapath.sv =====
module bqpp_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  bqpp_pkg::cmd_type                      cmd,
   input  logic                                   csr_we,
   input  logic [bqpp_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [bqpp_pkg::COEF_BITS-1:0]         csr_data,
   input  logic signed [bqpp_pkg::SAMPLE_BITS-1:0] req_sample_first,
   input  logic signed [bqpp_pkg::SAMPLE_BITS-1:0] req_sample_second,
   output logic signed [bqpp_pkg::SAMPLE_BITS-1:0] rsp_filtered_first,
   output logic signed [bqpp_pkg::SAMPLE_BITS-1:0] rsp_filtered_second
);

   localparam int AW = bqpp_pkg::ACC_BITS;
   localparam int CW = bqpp_pkg::COEF_BITS;
   localparam int SW = bqpp_pkg::SAMPLE_BITS;

   logic signed [CW-1:0] b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   logic signed [SW-1:0] x1_ff, x2_ff;
   logic [AW-1:0] outer_ff, inner_ff, y_ff, pb1_ff, pb2_ff;
   logic [AW-1:0] outer_in, inner_in, y_in, pb1_in, pb2_in;
   logic [SW-1:0] first_ff, out1_ff, out2_ff;
   logic signed [SW-1:0] x_sel;
   logic signed [AW-1:0] prod_b0, prod_b1, prod_b2;
   logic signed [AW-1:0] prod_a1, prod_a2;

   always_comb begin
      x_sel    = cmd.sel_second ? x2_ff : x1_ff;
      prod_b0  = AW'(b0_ff) * AW'(x_sel);
      prod_b1  = AW'(b1_ff) * AW'(x_sel);
      prod_b2  = AW'(b2_ff) * AW'(x_sel);
      y_in     = outer_ff + bqpp_pkg::scale(prod_b0);
      pb1_in   = bqpp_pkg::scale(prod_b1);
      pb2_in   = bqpp_pkg::scale(prod_b2);
      prod_a1  = AW'(a1_ff) * $signed(y_ff);
      prod_a2  = AW'(a2_ff) * $signed(y_ff);
      outer_in = inner_ff + pb1_ff + bqpp_pkg::scale(prod_a1);
      inner_in = pb2_ff + bqpp_pkg::scale(prod_a2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff    <= bqpp_pkg::B0_RESET;
         b1_ff    <= bqpp_pkg::B1_RESET;
         b2_ff    <= bqpp_pkg::B2_RESET;
         a1_ff    <= bqpp_pkg::A1_RESET;
         a2_ff    <= bqpp_pkg::A2_RESET;
         outer_ff <= '0;
         inner_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               bqpp_pkg::CSR_B0: b0_ff <= csr_data;
               bqpp_pkg::CSR_B1: b1_ff <= csr_data;
               bqpp_pkg::CSR_B2: b2_ff <= csr_data;
               bqpp_pkg::CSR_A1: a1_ff <= csr_data;
               bqpp_pkg::CSR_A2: a2_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.do_fb) begin
            outer_ff <= outer_in;
            inner_ff <= inner_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_samples) begin
         x1_ff <= req_sample_first;
         x2_ff <= req_sample_second;
      end
      if (cmd.do_prod) begin
         y_ff   <= y_in;
         pb1_ff <= pb1_in;
         pb2_ff <= pb2_in;
      end
      if (cmd.do_fb && !cmd.sel_second) first_ff <= y_ff[SW-1:0];
      if (cmd.load_out) begin
         out1_ff <= first_ff;
         out2_ff <= y_ff[SW-1:0];
      end
   end

   assign rsp_filtered_first  = out1_ff;
   assign rsp_filtered_second = out2_ff;

endmodule

// ===== rtl/core/bqpp_checker.sv =====
module bqpp_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_stall,
   input logic                                    rsp_valid,
   input logic                                    rsp_stall,
   input logic signed [bqpp_pkg::SAMPLE_BITS-1:0] rsp_filtered_first,
   input logic signed [bqpp_pkg::SAMPLE_BITS-1:0] rsp_filtered_second
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_filtered_first) && $stable(rsp_filtered_second))
      else $error("stalled result beat changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input beat taken while filter busy");

endmodule

bind biquad_iir_packed_pair_top bqpp_checker u_bqpp_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_filtered_first  (rsp_filtered_first),
   .rsp_filtered_second (rsp_filtered_second)
);
